>>> design/cobsrx_pkg.sv
// Shared types, status codes and the CRC-8/SMBUS byte update for the COBS frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package cobsrx_pkg;

	localparam logic [7:0] CRC_POLY = 8'h07;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CRC      = 2'd1,
		ST_FRAMING  = 2'd2,
		ST_OVERFLOW = 2'd3
	} frame_status_t;

	// one decoder event per accepted line byte
	typedef struct packed {
		logic          emit;
		logic          last;
		logic [7:0]    data;
		frame_status_t status;
	} rx_event_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> design/cobsrx_decode.sv
// Per-frame COBS decode, one-byte holdback and running CRC check.
// Depends on cobsrx_pkg.
`timescale 1ns / 1ps

module cobsrx_decode #(
	parameter int MAX_FRAME = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req,
	input  logic [7:0]            rx_byte,
	output cobsrx_pkg::rx_event_t ev
);
	import cobsrx_pkg::*;

	localparam int SC_W = $clog2(MAX_FRAME);

	logic [SC_W-1:0] stored_q, stored_d;
	logic [7:0]      group_left_q, group_left_d;
	logic            zero_owed_q, zero_owed_d;
	logic            held_valid_q, held_valid_d;
	logic [7:0]      held_byte_q, held_byte_d;
	logic [7:0]      crc_q, crc_d;
	logic            full;
	logic            push;
	logic [7:0]      push_byte;

	assign full = stored_q >= SC_W'(MAX_FRAME - 1);

	always_comb begin
		stored_d     = stored_q;
		group_left_d = group_left_q;
		zero_owed_d  = zero_owed_q;
		held_valid_d = held_valid_q;
		held_byte_d  = held_byte_q;
		crc_d        = crc_q;
		push         = 1'b0;
		push_byte    = rx_byte;
		ev           = '{emit: 1'b0, last: 1'b0, data: 8'd0, status: ST_OK};
		if (req) begin
			if (full || rx_byte == 8'd0) begin
				ev.emit = 1'b1;
				ev.last = 1'b1;
				if (full) begin
					ev.status = ST_OVERFLOW;
				end else if (group_left_q != 8'd0 || !held_valid_q) begin
					ev.status = ST_FRAMING;
				end else if (held_byte_q != crc_q) begin
					ev.status = ST_CRC;
				end else begin
					ev.status = ST_OK;
				end
				stored_d     = '0;
				group_left_d = 8'd0;
				zero_owed_d  = 1'b0;
				held_valid_d = 1'b0;
				held_byte_d  = 8'd0;
				crc_d        = 8'd0;
			end else begin
				stored_d = stored_q + 1'b1;
				if (group_left_q == 8'd0) begin
					// code byte: starts a group, releases the implied zero of the last one
					group_left_d = rx_byte - 8'd1;
					zero_owed_d  = rx_byte != 8'hFF;
					push         = zero_owed_q;
					push_byte    = 8'd0;
				end else begin
					group_left_d = group_left_q - 8'd1;
					push         = 1'b1;
				end
				if (push) begin
					if (held_valid_q) begin
						crc_d   = crc8_update(crc_q, held_byte_q);
						ev.emit = 1'b1;
						ev.data = held_byte_q;
					end
					held_byte_d  = push_byte;
					held_valid_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q     <= '0;
			group_left_q <= 8'd0;
			zero_owed_q  <= 1'b0;
			held_valid_q <= 1'b0;
			crc_q        <= 8'd0;
		end else begin
			stored_q     <= stored_d;
			group_left_q <= group_left_d;
			zero_owed_q  <= zero_owed_d;
			held_valid_q <= held_valid_d;
			crc_q        <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		held_byte_q <= held_byte_d;
	end

endmodule

>>> design/cobs_crc8_frame_receiver.sv
// Top level: COBS frame receiver with CRC-8/SMBUS check, status counters and output register.
// Depends on cobsrx_pkg and cobsrx_decode.
`timescale 1ns / 1ps
//
// channel | signals                        | carries
// s_*     | s_tvalid s_tready s_tdata[7:0] | encoded line bytes, zero ends a frame
// m_*     | m_tvalid m_tready m_tdata m_tlast | payload bytes, status item with tlast
//
// One line byte per cycle; the decode and CRC step sit between the state registers
// and the output register. s_tready is low only while the output register holds an
// untaken result and m_tready is low. Reset clears frame state, counters and m_tvalid.

module cobs_crc8_frame_receiver #(
	parameter int MAX_FRAME = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] payload_byte, [9:8] frame_status,
	                               // [25:10] errors_seen, [41:26] frames_good,
	                               // [42] overflow_seen, [47:43] zero
	output logic        m_tlast    // is_status
);
	import cobsrx_pkg::*;

	rx_event_t     ev;
	logic          req;
	logic [15:0]   err_q, err_d;
	logic [15:0]   good_q, good_d;
	logic          ovf_q, ovf_d;
	logic          valid_q;
	logic          last_q;
	logic [7:0]    data_q;
	frame_status_t status_q;
	logic [15:0]   err_out_q;
	logic [15:0]   good_out_q;
	logic          ovf_out_q;

	assign s_tready = !valid_q || m_tready;
	assign req      = s_tvalid && s_tready;

	cobsrx_decode #(
		.MAX_FRAME(MAX_FRAME)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rx_byte(s_tdata),
		.ev     (ev)
	);

	always_comb begin
		err_d  = err_q;
		good_d = good_q;
		ovf_d  = ovf_q;
		if (ev.emit && ev.last) begin
			if (ev.status == ST_OK) begin
				if (good_q != 16'hFFFF) begin
					good_d = good_q + 16'd1;
				end
				ovf_d = 1'b0;
			end else begin
				if (err_q != 16'hFFFF) begin
					err_d = err_q + 16'd1;
				end
				if (ev.status == ST_OVERFLOW) begin
					ovf_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= 16'd0;
			good_q  <= 16'd0;
			ovf_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			err_q   <= err_d;
			good_q  <= good_d;
			ovf_q   <= ovf_d;
			valid_q <= ev.emit || (valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (ev.emit) begin
			last_q     <= ev.last;
			data_q     <= ev.data;
			status_q   <= ev.status;
			err_out_q  <= err_d;
			good_out_q <= good_d;
			ovf_out_q  <= ovf_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {5'd0, ovf_out_q, good_out_q, err_out_q, status_q, data_q};

	a_err_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> err_q >= $past(err_q))
		else $error("error counter went down");

	a_good_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> good_q >= $past(good_q))
		else $error("good-frame counter went down");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !last_q) |-> status_q == ST_OK)
		else $error("payload item carries a status code");

	a_ovf_on_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q && status_q == ST_OVERFLOW) |-> ovf_out_q)
		else $error("overflow status without overflow flag");

	a_ovf_cleared_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q && status_q == ST_OK) |-> !ovf_out_q && data_q == 8'd0)
		else $error("good frame left overflow flag set or status data nonzero");

endmodule

>>> verif/testbench.sv
// Self-checking bench for cobs_crc8_frame_receiver: line bytes go in on the s_* stream and
// every m_* payload/status item is held to a built-in decoder/CRC predictor or typed row.
// Depends on cobsrx_pkg and the design files.
`timescale 1ns / 1ps

module testbench;
	import cobsrx_pkg::*;

	localparam int MAX_FRAME     = 64;
	localparam int RANDOM_ITEMS  = 1380;
	localparam int STALL_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 20;

	typedef struct packed {
		logic          is_status;
		logic [7:0]    payload;
		frame_status_t status;
		logic [15:0]   errors;
		logic [15:0]   good;
		logic          ovf;
	} rx_result_t;

	typedef struct {
		logic [7:0] line_byte;
		bit         typed;
		rx_result_t want;
	} stim_row_t;

	typedef logic [7:0] byte_q_t[$];

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;

	cobs_crc8_frame_receiver #(.MAX_FRAME(MAX_FRAME)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// predictor state
	int          frame_len;
	logic [7:0]  group_remaining;
	bit          zero_pending;
	bit          held_ok;
	logic [7:0]  held_data;
	logic [7:0]  crc_acc;
	logic [15:0] err_count;
	logic [15:0] good_count;
	bit          ovf_flag;

	rx_result_t  expected_results[$];
	stim_row_t   directed_rows[$];

	int send_gap_pct;
	int recv_gap_pct;
	int mismatches;
	int items_sent;
	int results_checked;
	int status_seen[4];
	bit stream_done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
		end
		return c;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic rx_result_t make_result(input logic is_st, input logic [7:0] data,
			input frame_status_t st);
		rx_result_t r;
		r.is_status = is_st;
		r.payload   = data;
		r.status    = st;
		r.errors    = err_count;
		r.good      = good_count;
		r.ovf       = ovf_flag;
		return r;
	endfunction

	function automatic rx_result_t status_item(input frame_status_t st, input int errs,
			input int goods, input bit ovf);
		rx_result_t r;
		r.is_status = 1'b1;
		r.payload   = 8'h00;
		r.status    = st;
		r.errors    = 16'(errs);
		r.good      = 16'(goods);
		r.ovf       = ovf;
		return r;
	endfunction

	task automatic restart_frame();
		frame_len       = 0;
		group_remaining = 8'h00;
		zero_pending    = 1'b0;
		held_ok         = 1'b0;
		held_data       = 8'h00;
		crc_acc         = 8'h00;
	endtask

	// one decoded byte: releases the held byte (if any) as payload
	task automatic take_decoded(input logic [7:0] b, output bit got, output rx_result_t r);
		got = 1'b0;
		r   = '0;
		if (held_ok) begin
			crc_acc = crc8_step(crc_acc, held_data);
			r       = make_result(1'b0, held_data, ST_OK);
			got     = 1'b1;
		end
		held_data = b;
		held_ok   = 1'b1;
	endtask

	task automatic predict_line_byte(input logic [7:0] b, output bit got, output rx_result_t r);
		bit            owed;
		frame_status_t st;
		got = 1'b0;
		r   = '0;
		if (frame_len + 1 >= MAX_FRAME) begin
			ovf_flag  = 1'b1;
			err_count = sat_inc(err_count);
			restart_frame();
			r   = make_result(1'b1, 8'h00, ST_OVERFLOW);
			got = 1'b1;
		end else if (b == 8'h00) begin
			if (group_remaining != 8'h00 || !held_ok) begin
				st        = ST_FRAMING;
				err_count = sat_inc(err_count);
			end else if (held_data != crc_acc) begin
				st        = ST_CRC;
				err_count = sat_inc(err_count);
			end else begin
				st         = ST_OK;
				good_count = sat_inc(good_count);
				ovf_flag   = 1'b0;
			end
			restart_frame();
			r   = make_result(1'b1, 8'h00, st);
			got = 1'b1;
		end else begin
			frame_len++;
			if (group_remaining == 8'h00) begin
				owed            = zero_pending;
				group_remaining = b - 8'd1;
				zero_pending    = (b != 8'hFF);
				if (owed) begin
					take_decoded(8'h00, got, r);
				end
			end else begin
				group_remaining--;
				take_decoded(b, got, r);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
	endtask

	// sends one line byte, then books the expected result once the request is taken
	task automatic send_line_byte(input logic [7:0] b, input bit typed, input rx_result_t want);
		bit         got;
		rx_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		predict_line_byte(b, got, r);
		if (typed) begin
			expected_results.insert(expected_results.size(), want);
		end else if (got) begin
			expected_results.insert(expected_results.size(), r);
		end
	endtask

	task automatic send_bytes(input byte_q_t line);
		foreach (line[i]) begin
			send_line_byte(line[i], 1'b0, '0);
		end
	endtask

	task automatic add_row(input logic [7:0] b);
		stim_row_t row;
		row.line_byte = b;
		row.typed     = 1'b0;
		row.want      = '0;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic add_typed(input logic [7:0] b, input rx_result_t want);
		stim_row_t row;
		row.line_byte = b;
		row.typed     = 1'b1;
		row.want      = want;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	task automatic cobs_encode(input byte_q_t dec, ref byte_q_t line);
		byte_q_t grp;
		line = {};
		grp  = {};
		foreach (dec[i]) begin
			if (dec[i] == 8'h00) begin
				line.insert(line.size(), 8'(grp.size() + 1));
				line = {line, grp};
				grp  = {};
			end else begin
				grp.insert(grp.size(), dec[i]);
				if (grp.size() == 254) begin
					line.insert(line.size(), 8'hFF);
					line = {line, grp};
					grp  = {};
				end
			end
		end
		line.insert(line.size(), 8'(grp.size() + 1));
		line = {line, grp};
		line.insert(line.size(), 8'h00);
	endtask

	// mostly well-formed frames; some with a bad CRC, cut short, or plain noise
	task automatic make_random_frame(ref byte_q_t line);
		byte_q_t    dec;
		logic [7:0] crc;
		int         n;
		int         kind;
		int         cut;
		dec  = {};
		crc  = 8'h00;
		kind = $urandom_range(99);
		if (kind >= 90) begin
			line = {};
			n = $urandom_range(1, 12);
			repeat (n) begin
				line.insert(line.size(),
					($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
			end
		end else begin
			n = ($urandom_range(4) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 20);
			repeat (n) begin
				dec.insert(dec.size(),
					($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
			end
			foreach (dec[i]) begin
				crc = crc8_step(crc, dec[i]);
			end
			if (kind >= 65 && kind < 78) begin
				crc = crc ^ 8'($urandom_range(1, 255));
			end
			dec.insert(dec.size(), crc);
			cobs_encode(dec, line);
			if (kind >= 78) begin
				cut = $urandom_range(1, 3);
				while (cut > 0 && line.size() > 1) begin
					line.delete(line.size() - 2);
					cut--;
				end
			end
		end
	endtask

	// receiver side
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// checker
	initial begin
		rx_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", m_tdata, 0);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.is_status) begin
						status_seen[want.status]++;
					end
					if (m_tlast !== want.is_status)
						report_mismatch("is_status", m_tlast, want.is_status);
					if (m_tdata[7:0] !== want.payload)
						report_mismatch("payload_byte", m_tdata[7:0], want.payload);
					if (m_tdata[9:8] !== want.status)
						report_mismatch("frame_status", m_tdata[9:8], want.status);
					if (m_tdata[25:10] !== want.errors)
						report_mismatch("errors_seen", m_tdata[25:10], want.errors);
					if (m_tdata[41:26] !== want.good)
						report_mismatch("frames_good", m_tdata[41:26], want.good);
					if (m_tdata[42] !== want.ovf)
						report_mismatch("overflow_seen", m_tdata[42], want.ovf);
					if (m_tdata[47:43] !== 5'd0)
						report_mismatch("tdata pad", m_tdata[47:43], 0);
				end
			end
		end
	end

	// watchdog: no request moved on either side for too long
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || stream_done) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= STALL_LIMIT) begin
				$display("watchdog: no traffic for %0d cycles, %0d results outstanding",
					STALL_LIMIT, expected_results.size());
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin
		byte_q_t line;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = 8'h00;
		send_gap_pct    = 35;
		recv_gap_pct    = 66;
		mismatches      = 0;
		items_sent      = 0;
		results_checked = 0;
		stream_done     = 1'b0;
		foreach (status_seen[i]) status_seen[i] = 0;
		restart_frame();
		err_count  = 16'd0;
		good_count = 16'd0;
		ovf_flag   = 1'b0;

		// empty frame right after reset
		add_typed(8'h00, status_item(ST_FRAMING, 1, 0, 1'b0));
		// only a code byte, no data
		add_row(8'h01);
		add_typed(8'h00, status_item(ST_FRAMING, 2, 0, 1'b0));
		// truncated group
		add_row(8'h05);
		add_row(8'h11);
		add_typed(8'h00, status_item(ST_FRAMING, 3, 0, 1'b0));
		// full-length code with no data behind it
		add_row(8'hFF);
		add_typed(8'h00, status_item(ST_FRAMING, 4, 0, 1'b0));
		// good frame, payload 0xFF
		add_row(8'h03);
		add_row(8'hFF);
		add_row(8'hF3);
		add_row(8'h00);
		// bad CRC
		add_row(8'h03);
		add_row(8'h12);
		add_row(8'h34);
		add_typed(8'h00, status_item(ST_CRC, 5, 1, 1'b0));
		// implied zeros: payload 0x00, CRC 0x00
		add_row(8'h01);
		add_row(8'h01);
		add_row(8'h01);
		add_row(8'h00);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_line_byte(directed_rows[i].line_byte, directed_rows[i].typed,
				directed_rows[i].want);
		end

		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent < RANDOM_ITEMS / 3) begin
				send_gap_pct = 35;
				recv_gap_pct = 66;
			end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
				send_gap_pct = 66;
				recv_gap_pct = 35;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			make_random_frame(line);
			send_bytes(line);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		stream_done = 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d line bytes, %0d results checked, %0d mismatches",
			items_sent, results_checked, mismatches);
		$display("frame ends: ok %0d, crc %0d, framing %0d, overflow %0d",
			status_seen[ST_OK], status_seen[ST_CRC], status_seen[ST_FRAMING],
			status_seen[ST_OVERFLOW]);
		if (mismatches == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
